FILE: design/slot_flag_packet_ring_macros.svh
// Assertion macros used by the packet ring checker.
`ifndef SLOT_FLAG_PACKET_RING_MACROS_SVH
`define SLOT_FLAG_PACKET_RING_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define SFPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define SFPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/sfpr_pkg.sv
// Types, codes and defaults shared by the packet ring modules.
package sfpr_pkg;

	localparam int SLOT_COUNT_DEF  = 16;
	localparam int PACKET_BITS_DEF = 64;

	localparam logic MODE_STORE = 1'b0;
	localparam logic MODE_FETCH = 1'b1;

	typedef enum logic [2:0] {
		ST_STORED       = 3'd0,
		ST_STORE_FAILED = 3'd1,
		ST_FULL         = 3'd2,
		ST_FETCHED      = 3'd3,
		ST_FETCH_FAILED = 3'd4,
		ST_EMPTY        = 3'd5
	} status_t;

	typedef struct packed {
		logic        mode;
		logic [63:0] packet_in;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] packet_out;
		logic [4:0]  packets_held;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic take;      // execute the incoming transaction this cycle
		logic load_out;  // move the pending result into the output register
	} dp_cmd_t;

endpackage

FILE: design/sfpr_ctrl.sv
// Controller: sequences one transaction through execute and result load.
module sfpr_ctrl import sfpr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || !out_stall;
	assign in_stall     = (state_q != S_IDLE);
	assign cmd.take     = in_valid && (state_q == S_IDLE);
	assign cmd.load_out = (state_q == S_RESULT) && out_free;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.take) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/sfpr_datapath.sv
// Datapath: slot flags, ring positions, packet count, payload memory, result register.
module sfpr_datapath import sfpr_pkg::*; #(
	parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
	parameter int PACKET_BITS = PACKET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	input  in_item_t  in_data,
	output out_item_t out_data
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	logic [SLOT_COUNT-1:0]  flags_q;
	logic [IDX_W-1:0]       write_pos_q;
	logic [IDX_W-1:0]       read_pos_q;
	logic [CNT_W-1:0]       count_q;
	status_t                status_q;
	out_item_t              out_q;

	logic [PACKET_BITS-1:0] mem [SLOT_COUNT];
	logic [PACKET_BITS-1:0] rd_s1;

	logic [IDX_W-1:0]        start;
	logic [SLOT_COUNT-1:0]   search_vec;
	logic [2*SLOT_COUNT-1:0] dbl;
	logic [IDX_W-1:0]        ofs;
	logic [IDX_W:0]          sum;
	logic [IDX_W-1:0]        slot;
	logic                    is_full;
	logic                    is_empty;
	logic                    do_store;
	logic                    do_fetch;

	// index of the lowest set bit; isolate it, then encode
	function automatic logic [IDX_W-1:0] first_set(input logic [SLOT_COUNT-1:0] v);
		logic [SLOT_COUNT-1:0] low;
		logic [IDX_W-1:0]      idx;
		low = v & (~v + 1'b1);
		idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (low[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		return idx;
	endfunction

	always_comb begin
		if (in_data.mode == MODE_STORE) begin
			start      = (write_pos_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : write_pos_q + 1'b1;
			search_vec = ~flags_q;
		end else begin
			start      = read_pos_q;
			search_vec = flags_q;
		end
	end

	// rotate so the search start sits at bit 0, find, then map back onto the ring
	assign dbl  = {search_vec, search_vec} >> start;
	assign ofs  = first_set(dbl[SLOT_COUNT-1:0]);
	assign sum  = {1'b0, start} + {1'b0, ofs};
	assign slot = (sum >= (IDX_W + 1)'(SLOT_COUNT)) ?
		IDX_W'(sum - (IDX_W + 1)'(SLOT_COUNT)) : sum[IDX_W-1:0];

	// count below depth guarantees a free slot; nonzero count guarantees a full one
	assign is_full  = (count_q == CNT_W'(SLOT_COUNT));
	assign is_empty = (count_q == '0);
	assign do_store = cmd.take && (in_data.mode == MODE_STORE) && !is_full;
	assign do_fetch = cmd.take && (in_data.mode == MODE_FETCH) && !is_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			write_pos_q <= '0;
			read_pos_q  <= '0;
			count_q     <= '0;
		end else begin
			if (do_store) begin
				flags_q[slot] <= 1'b1;
				write_pos_q   <= slot;
				count_q       <= count_q + 1'b1;
			end else if (do_fetch) begin
				flags_q[slot] <= 1'b0;
				read_pos_q    <= slot;
				count_q       <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_store) begin
			mem[slot] <= in_data.packet_in[PACKET_BITS-1:0];
		end
		if (do_fetch) begin
			rd_s1 <= mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (in_data.mode == MODE_STORE) begin
				status_q <= is_full ? ST_FULL : ST_STORED;
			end else begin
				status_q <= is_empty ? ST_EMPTY : ST_FETCHED;
			end
		end
		if (cmd.load_out) begin
			out_q.status       <= status_q;
			out_q.packet_out   <= (status_q == ST_FETCHED) ? 64'(rd_s1) : '0;
			out_q.packets_held <= 5'(count_q);
		end
	end

	assign out_data = out_q;

endmodule

FILE: design/slot_flag_packet_ring.sv
// A result passes two registers: the accept cycle runs the slot-flag find and the payload
// memory write or read into the status and read registers, and the result state then
// loads the output register, waiting there while the output is stalled. No new
// transaction is accepted until the result has moved into the output register.
// Reset clears slot flags, positions and count at once; the payload memory is not
// cleared, since only slots flagged full are ever read.
module slot_flag_packet_ring import sfpr_pkg::*; #(
	parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
	parameter int PACKET_BITS = PACKET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	dp_cmd_t cmd;

	sfpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sfpr_datapath #(
		.SLOT_COUNT  (SLOT_COUNT),
		.PACKET_BITS (PACKET_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

FILE: design/sfpr_checker.sv
// Port-level checker for the packet ring, bound to the top level.
`include "slot_flag_packet_ring_macros.svh"

module sfpr_checker import sfpr_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	localparam logic [4:0] HELD_AT_FULL = 5'(SLOT_COUNT);

	logic in_taken;
	assign in_taken = in_valid && !in_stall && (in_data.mode == MODE_STORE || in_data.mode == MODE_FETCH);

	`SFPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed or dropped")
	`SFPR_ASSERT_NEXT(a_one_in_flight, in_taken, in_stall, "second transaction taken while one is in flight")
	`SFPR_ASSERT_NOW(a_status_code, out_valid, out_data.status == ST_STORED || out_data.status == ST_FULL || out_data.status == ST_FETCHED || out_data.status == ST_EMPTY, "unreachable status reported")
	`SFPR_ASSERT_NOW(a_payload_zero, out_valid && out_data.status != ST_FETCHED, out_data.packet_out == 64'd0, "payload shown without a fetch")
	`SFPR_ASSERT_NOW(a_full_count, out_valid && out_data.status == ST_FULL, out_data.packets_held == HELD_AT_FULL, "buffer full with count below depth")

endmodule

bind slot_flag_packet_ring sfpr_checker #(.SLOT_COUNT(SLOT_COUNT)) u_sfpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
